// ===== hw/rtl/dual_cpu_address_decoder_assert.svh =====
// ----------------------------------------------------------------------------
// Dual CPU address decoder assertion macros
// Shared assertion forms, sampled on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef DUAL_CPU_ADDRESS_DECODER_ASSERT_SVH
`define DUAL_CPU_ADDRESS_DECODER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DCAD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dcad: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define DCAD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dcad: next-cycle check failed");

`endif

// ===== hw/rtl/dcad_pkg.sv =====
// ----------------------------------------------------------------------------
// Dual CPU address decoder package
// Types, codes and address constants shared by the decoder modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dcad_pkg;

    // Width of the main memory offset.
    localparam int MAIN_ADDR_BITS = 22;
    localparam logic [31:0] MAIN_MASK = 32'((64'd1 << MAIN_ADDR_BITS) - 64'd1);

    // Address map constants.
    localparam logic [31:0] BANK_CTL_ADDR  = 32'h0400_0247;
    localparam logic [31:0] VRAM_LCDC_BASE = 32'h0680_0000;
    localparam logic [31:0] PRIV_BASE      = 32'h0380_0000;
    localparam logic [31:0] MASK_16K       = 32'h0000_3FFF;
    localparam logic [31:0] MASK_32K       = 32'h0000_7FFF;
    localparam logic [31:0] MASK_64K       = 32'h0000_FFFF;
    localparam logic [31:0] UPPER_16K      = 32'h0000_4000;

    // Top address bytes of the regions.
    localparam logic [7:0] REGION_BIOS7 = 8'h00;
    localparam logic [7:0] REGION_MAIN  = 8'h02;
    localparam logic [7:0] REGION_WRAM  = 8'h03;
    localparam logic [7:0] REGION_IO    = 8'h04;
    localparam logic [7:0] REGION_VRAM  = 8'h06;
    localparam logic [7:0] REGION_BIOS9 = 8'hFF;

    // Stream widths.
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 72;

    // Depth of the queue between front and back.
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Configuration port.
    localparam int CFG_ADDR_W = 5;

    typedef enum logic [2:0] {
        REG_ITCM_ENABLE = 3'd0,
        REG_ITCM_LIMIT  = 3'd1,
        REG_DTCM_ENABLE = 3'd2,
        REG_DTCM_BASE   = 3'd3,
        REG_DTCM_LENGTH = 3'd4
    } reg_index_t;

    typedef enum logic [1:0] {
        SIZE_BYTE = 2'd0,
        SIZE_HALF = 2'd1,
        SIZE_WORD = 2'd2
    } size_t;

    typedef enum logic [3:0] {
        TGT_UNMAPPED = 4'd0,
        TGT_MAIN     = 4'd1,
        TGT_SHARED   = 4'd2,
        TGT_PRIVATE  = 4'd3,
        TGT_BIOS7    = 4'd4,
        TGT_BIOS9    = 4'd5,
        TGT_ITCM     = 4'd6,
        TGT_DTCM     = 4'd7,
        TGT_IO       = 4'd8,
        TGT_VRAM     = 4'd9,
        TGT_ZERO     = 4'd10,
        TGT_BANKCTL  = 4'd11
    } target_t;

    // What the back part still has to do with a classified access.
    typedef enum logic [1:0] {
        KIND_DONE    = 2'd0,
        KIND_WRAM7   = 2'd1,
        KIND_WRAM9   = 2'd2,
        KIND_BANKCTL = 2'd3
    } kind_t;

    typedef struct packed {
        logic        itcm_enable;
        logic [31:0] itcm_limit;
        logic        dtcm_enable;
        logic [31:0] dtcm_base;
        logic [31:0] dtcm_length;
    } cfg_t;

    typedef struct packed {
        kind_t       kind;
        target_t     target;
        logic [31:0] offset;
        logic [31:0] aligned;
        logic [1:0]  bank_data;
    } item_t;

endpackage

// ===== hw/rtl/dcad_front.sv =====
// ----------------------------------------------------------------------------
// Dual CPU address decoder front part
// Accepts accesses, aligns them and classifies them by requester and region.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dcad_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  dcad_pkg::cfg_t                   cfg,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [dcad_pkg::IN_DATA_W-1:0]   s_data,
    output logic                             item_valid,
    input  logic                             item_ready,
    output dcad_pkg::item_t                  item
);
    import dcad_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    item_t       item_reg;
    item_t       item_next;

    logic        wr;
    logic        second;
    logic [1:0]  size;
    logic [31:0] addr;
    logic [31:0] data;
    logic [31:0] a;
    logic [31:0] dtcm_diff;
    logic        itcm_hit;
    logic        dtcm_hit;

    // Unpack the transfer.
    assign wr     = s_data[0];
    assign second = s_data[1];
    assign size   = s_data[3:2];
    assign addr   = s_data[35:4];
    assign data   = s_data[67:36];

    // Align the address to the access size; size code three acts as a word.
    always_comb
    begin
        case (size)
            SIZE_BYTE: a = addr;
            SIZE_HALF: a = {addr[31:1], 1'b0};
            default:   a = {addr[31:2], 2'b00};
        endcase
    end

    // TCM window tests for the second processor.
    assign dtcm_diff = a - cfg.dtcm_base;
    assign itcm_hit  = cfg.itcm_enable && (a < cfg.itcm_limit);
    assign dtcm_hit  = cfg.dtcm_enable && (a >= cfg.dtcm_base) &&
                       (dtcm_diff < cfg.dtcm_length);

    // Classification into a final target or a bank dependent kind.
    always_comb
    begin
        item_next.kind      = KIND_DONE;
        item_next.target    = TGT_UNMAPPED;
        item_next.offset    = '0;
        item_next.aligned   = a;
        item_next.bank_data = data[1:0];
        if (second)
        begin
            if (itcm_hit)
            begin
                item_next.target = TGT_ITCM;
                item_next.offset = a & MASK_32K;
            end
            else if (dtcm_hit)
            begin
                item_next.target = TGT_DTCM;
                item_next.offset = dtcm_diff & MASK_16K;
            end
            else
            begin
                case (a[31:24])
                    REGION_MAIN:
                    begin
                        item_next.target = TGT_MAIN;
                        item_next.offset = a & MAIN_MASK;
                    end
                    REGION_WRAM:
                    begin
                        item_next.kind = KIND_WRAM9;
                    end
                    REGION_IO:
                    begin
                        item_next.offset = a;
                        if (wr && (size == SIZE_BYTE) && (a == BANK_CTL_ADDR))
                        begin
                            item_next.kind   = KIND_BANKCTL;
                            item_next.target = TGT_BANKCTL;
                        end
                        else
                        begin
                            item_next.target = TGT_IO;
                        end
                    end
                    REGION_VRAM:
                    begin
                        if (a >= VRAM_LCDC_BASE)
                        begin
                            item_next.target = TGT_VRAM;
                            item_next.offset = a;
                        end
                    end
                    REGION_BIOS9:
                    begin
                        if (wr)
                        begin
                            item_next.target = TGT_ZERO;
                        end
                        else
                        begin
                            item_next.target = TGT_BIOS9;
                            item_next.offset = a & MASK_32K;
                        end
                    end
                    default:
                    begin
                        item_next.target = TGT_UNMAPPED;
                    end
                endcase
            end
        end
        else
        begin
            case (a[31:24])
                REGION_BIOS7:
                begin
                    if (wr)
                    begin
                        item_next.target = TGT_ZERO;
                    end
                    else
                    begin
                        item_next.target = TGT_BIOS7;
                        item_next.offset = a & MASK_16K;
                    end
                end
                REGION_MAIN:
                begin
                    item_next.target = TGT_MAIN;
                    item_next.offset = a & MAIN_MASK;
                end
                REGION_WRAM:
                begin
                    if (a >= PRIV_BASE)
                    begin
                        item_next.target = TGT_PRIVATE;
                        item_next.offset = a & MASK_64K;
                    end
                    else
                    begin
                        item_next.kind = KIND_WRAM7;
                    end
                end
                REGION_IO:
                begin
                    item_next.target = TGT_IO;
                    item_next.offset = a;
                end
                default:
                begin
                    item_next.target = TGT_UNMAPPED;
                end
            endcase
        end
    end

    // Stage register: takes a new transfer whenever it is empty or draining.
    assign s_ready    = !valid_reg || item_ready;
    assign valid_next = (s_valid && s_ready) ? 1'b1 :
                        (item_ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_valid && s_ready)
        begin
            item_reg <= item_next;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== hw/rtl/dcad_queue.sv =====
// ----------------------------------------------------------------------------
// Dual CPU address decoder queue
// Short first-in first-out buffer between the front and back parts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "dual_cpu_address_decoder_assert.svh"

module dcad_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  dcad_pkg::item_t in_item,
    output logic            out_valid,
    input  logic            out_ready,
    output dcad_pkg::item_t out_item
);
    import dcad_pkg::*;

    item_t                mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg;
    logic [Q_PTR_W-1:0]   wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg;
    logic [Q_PTR_W-1:0]   rd_ptr_next;
    logic [Q_CNT_W-1:0]   count_reg;
    logic [Q_CNT_W-1:0]   count_next;
    logic                 push;
    logic                 pop;

    assign in_ready  = (count_reg != Q_CNT_W'(Q_DEPTH));
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_item  = mem_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 :
                          wr_ptr_reg + Q_PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 :
                          rd_ptr_reg + Q_PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + Q_CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage write.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

    // The fill count never runs past the depth, and pushes without pops raise it.
    `DCAD_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= Q_CNT_W'(Q_DEPTH))
    `DCAD_ASSERT_NEXT(a_count_up, push && !pop, count_reg == $past(count_reg) + Q_CNT_W'(1))

endmodule

// ===== hw/rtl/dcad_back.sv =====
// ----------------------------------------------------------------------------
// Dual CPU address decoder back part
// Holds the bank mode, resolves work RAM accesses and registers the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "dual_cpu_address_decoder_assert.svh"

module dcad_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    output logic                            item_ready,
    input  dcad_pkg::item_t                 item,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [dcad_pkg::OUT_DATA_W-1:0] m_data
);
    import dcad_pkg::*;

    logic        take;
    logic [1:0]  bank_mode_reg;
    logic [1:0]  bank_mode_next;
    logic        m_valid_reg;
    logic        m_valid_next;
    target_t     target_reg;
    target_t     target_next;
    logic [31:0] offset_reg;
    logic [31:0] offset_next;
    logic [31:0] aligned_reg;
    logic [1:0]  mode_out_reg;

    assign item_ready = !m_valid_reg || m_ready;
    assign take       = item_valid && item_ready;

    // Resolve bank dependent accesses and the bank control write.
    always_comb
    begin
        target_next    = item.target;
        offset_next    = item.offset;
        bank_mode_next = bank_mode_reg;
        case (item.kind)
            KIND_WRAM7:
            begin
                case (bank_mode_reg)
                    2'd0:
                    begin
                        target_next = TGT_PRIVATE;
                        offset_next = item.aligned & MASK_64K;
                    end
                    2'd1:
                    begin
                        target_next = TGT_SHARED;
                        offset_next = item.aligned & MASK_16K;
                    end
                    2'd2:
                    begin
                        target_next = TGT_SHARED;
                        offset_next = (item.aligned & MASK_16K) | UPPER_16K;
                    end
                    default:
                    begin
                        target_next = TGT_SHARED;
                        offset_next = item.aligned & MASK_32K;
                    end
                endcase
            end
            KIND_WRAM9:
            begin
                case (bank_mode_reg)
                    2'd0:
                    begin
                        target_next = TGT_SHARED;
                        offset_next = item.aligned & MASK_32K;
                    end
                    2'd1:
                    begin
                        target_next = TGT_SHARED;
                        offset_next = (item.aligned & MASK_16K) | UPPER_16K;
                    end
                    2'd2:
                    begin
                        target_next = TGT_SHARED;
                        offset_next = item.aligned & MASK_16K;
                    end
                    default:
                    begin
                        target_next = TGT_ZERO;
                        offset_next = '0;
                    end
                endcase
            end
            KIND_BANKCTL:
            begin
                bank_mode_next = item.bank_data;
            end
            default:
            begin
                target_next = item.target;
            end
        endcase
    end

    // Control state: bank mode and result valid.
    assign m_valid_next = take ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_mode_reg <= 2'd0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                bank_mode_reg <= bank_mode_next;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            target_reg   <= target_next;
            offset_reg   <= offset_next;
            aligned_reg  <= item.aligned;
            mode_out_reg <= bank_mode_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = {2'b00, mode_out_reg, aligned_reg, offset_reg, target_reg};

    // The bank mode moves only on a bank control transfer, and then to its data.
    `DCAD_ASSERT_NEXT(a_mode_hold, !(take && item.kind == KIND_BANKCTL), $stable(bank_mode_reg))
    `DCAD_ASSERT_NEXT(a_mode_load, take && item.kind == KIND_BANKCTL, bank_mode_reg == $past(item.bank_data))

endmodule

// ===== hw/rtl/dual_cpu_address_decoder.sv =====
// ----------------------------------------------------------------------------
// Dual CPU address decoder
// Maps bus accesses of two processors to target memories and local offsets.
// ----------------------------------------------------------------------------
//  Channel  | Ports                          | Contents
//  ---------+--------------------------------+--------------------------------
//  input    | s_axis_tvalid/tready/tdata     | one bus access per transfer
//  output   | m_axis_tvalid/tready/tdata     | one decoded result per access
//  config   | psel/penable/pwrite/paddr/...  | TCM window registers
//
//  An access passes the front stage register, the queue and the result
//  register on its way from input transfer to output. A new access is taken
//  every cycle while the output drains; the only serial dependency is the
//  bank mode, kept in the back part in access order. Reset clears the
//  configuration registers, the bank mode and all valid flags. An output
//  stall fills the result register, queue and front stage before tready drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dual_cpu_address_decoder (
    input  logic                                clk,
    input  logic                                rst_n,
    // Input transfer.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata: op[0], requester[1], access_size[3:2], address[35:4],
    // write_data[67:36], zero fill[71:68].
    input  logic [dcad_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // Output transfer.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata: target[3:0], local_offset[35:4], aligned_address[67:36],
    // bank_mode_now[69:68], zero fill[71:70].
    output logic [dcad_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // Configuration port.
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [dcad_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);
    import dcad_pkg::*;

    cfg_t       cfg_reg;
    logic       cfg_write;
    reg_index_t reg_index;
    logic       fe_valid;
    logic       fe_ready;
    item_t      fe_item;
    logic       q_valid;
    logic       q_ready;
    item_t      q_item;

    // Register file.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_index = reg_index_t'(paddr[CFG_ADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (reg_index)
                REG_ITCM_ENABLE: cfg_reg.itcm_enable <= pwdata[0];
                REG_ITCM_LIMIT:  cfg_reg.itcm_limit  <= pwdata;
                REG_DTCM_ENABLE: cfg_reg.dtcm_enable <= pwdata[0];
                REG_DTCM_BASE:   cfg_reg.dtcm_base   <= pwdata;
                REG_DTCM_LENGTH: cfg_reg.dtcm_length <= pwdata;
                default:         cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Register read back.
    always_comb
    begin
        case (reg_index)
            REG_ITCM_ENABLE: prdata = {31'd0, cfg_reg.itcm_enable};
            REG_ITCM_LIMIT:  prdata = cfg_reg.itcm_limit;
            REG_DTCM_ENABLE: prdata = {31'd0, cfg_reg.dtcm_enable};
            REG_DTCM_BASE:   prdata = cfg_reg.dtcm_base;
            REG_DTCM_LENGTH: prdata = cfg_reg.dtcm_length;
            default:         prdata = '0;
        endcase
    end

    // Front part: alignment and classification.
    dcad_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .s_valid    (s_axis_tvalid),
        .s_ready    (s_axis_tready),
        .s_data     (s_axis_tdata),
        .item_valid (fe_valid),
        .item_ready (fe_ready),
        .item       (fe_item)
    );

    // Queue between the two parts.
    dcad_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fe_valid),
        .in_ready  (fe_ready),
        .in_item   (fe_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    // Back part: bank mode and result register.
    dcad_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (q_valid),
        .item_ready (q_ready),
        .item       (q_item),
        .m_valid    (m_axis_tvalid),
        .m_ready    (m_axis_tready),
        .m_data     (m_axis_tdata)
    );

endmodule

// ===== tb/sv/dual_cpu_address_decoder_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual CPU address decoder testbench
// Streams bus accesses from both processors into the decoder and checks every
// decoded result against an in-bench prediction of target, offset, alignment
// and bank mode. It covers five TCM window settings, uneven idling on both
// stream sides and a long output stall that backs up the input.
// ----------------------------------------------------------------------------

module dual_cpu_address_decoder_tb;
    import dcad_pkg::*;

    localparam int CLK_PERIOD       = 12;
    localparam int RESET_CYCLES     = 8;
    localparam int RANDOM_PER_PHASE = 210;
    localparam int PHASE_COUNT      = 4;
    localparam int LONG_HOLD        = 80;
    localparam int DRAIN_CYCLES     = 6;
    localparam int CYCLE_LIMIT      = 400000;

    // Access codes of the input stream.
    localparam logic       OP_READ    = 1'b0;
    localparam logic       OP_WRITE   = 1'b1;
    localparam logic       CPU_FIRST  = 1'b0;
    localparam logic       CPU_SECOND = 1'b1;
    localparam logic [1:0] SIZE_CODE3 = 2'd3;

    // Shared work RAM split modes.
    localparam logic [1:0] SPLIT_ALL_SECOND = 2'd0;
    localparam logic [1:0] SPLIT_LOW_FIRST  = 2'd1;
    localparam logic [1:0] SPLIT_HIGH_FIRST = 2'd2;
    localparam logic [1:0] SPLIT_ALL_FIRST  = 2'd3;

    typedef struct packed {
        logic        op;
        logic        cpu;
        logic [1:0]  size;
        logic [31:0] address;
        logic [31:0] data;
    } access_t;

    typedef struct packed {
        target_t     target;
        logic [31:0] offset;
        logic [31:0] aligned;
        logic [1:0]  split;
    } decode_t;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // tdata: op, requester, access_size, address, write_data, zero fill.
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // tdata: target, local_offset, aligned_address, bank_mode_now, zero fill.
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  psel          = 1'b0;
    logic                  penable       = 1'b0;
    logic                  pwrite        = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr         = '0;
    logic [31:0]           pwdata        = '0;
    logic [31:0]           prdata;
    logic                  pready;

    // Bench copy of the window registers and the bank mode.
    logic        itcm_on    = 1'b0;
    logic [31:0] itcm_top   = '0;
    logic        dtcm_on    = 1'b0;
    logic [31:0] dtcm_start = '0;
    logic [31:0] dtcm_span  = '0;
    logic [1:0]  wram_split = SPLIT_ALL_SECOND;

    access_t access_queue[$];
    decode_t expected_decodes[$];
    access_t offered;

    int queued_count    = 0;
    int accepted_count  = 0;
    int results_checked = 0;
    int mismatch_count  = 0;
    int send_idle_pct   = 0;
    int recv_idle_pct   = 0;
    int hold_requests   = 0;
    int holds_served    = 0;
    int hold_left       = 0;
    int stalled_cycles  = 0;
    int tcm_hits        = 0;
    int bank_writes     = 0;
    int cycle_count     = 0;

    dual_cpu_address_decoder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Predicts one decoded result and applies a bank control write.
    function automatic decode_t decode_access(input access_t acc);
        decode_t     res;
        logic [31:0] a;
        case (acc.size)
            SIZE_BYTE: a = acc.address;
            SIZE_HALF: a = acc.address & ~32'd1;
            default:   a = acc.address & ~32'd3;
        endcase
        res.aligned = a;
        res.target  = TGT_UNMAPPED;
        res.offset  = '0;
        if (acc.cpu == CPU_FIRST)
        begin
            case (a[31:24])
                REGION_BIOS7:
                begin
                    if (acc.op == OP_WRITE)
                        res.target = TGT_ZERO;
                    else
                    begin
                        res.target = TGT_BIOS7;
                        res.offset = a & MASK_16K;
                    end
                end
                REGION_MAIN:
                begin
                    res.target = TGT_MAIN;
                    res.offset = a & MAIN_MASK;
                end
                REGION_WRAM:
                begin
                    // The upper half of the region is always private RAM.
                    if (a >= PRIV_BASE || wram_split == SPLIT_ALL_SECOND)
                    begin
                        res.target = TGT_PRIVATE;
                        res.offset = a & MASK_64K;
                    end
                    else
                    begin
                        res.target = TGT_SHARED;
                        case (wram_split)
                            SPLIT_LOW_FIRST:  res.offset = a & MASK_16K;
                            SPLIT_HIGH_FIRST: res.offset = (a & MASK_16K) + UPPER_16K;
                            default:          res.offset = a & MASK_32K;
                        endcase
                    end
                end
                REGION_IO:
                begin
                    res.target = TGT_IO;
                    res.offset = a;
                end
                default:
                begin
                end
            endcase
        end
        else if (itcm_on && a < itcm_top)
        begin
            res.target = TGT_ITCM;
            res.offset = a & MASK_32K;
            tcm_hits++;
        end
        else if (dtcm_on && a >= dtcm_start && (a - dtcm_start) < dtcm_span)
        begin
            res.target = TGT_DTCM;
            res.offset = (a - dtcm_start) & MASK_16K;
            tcm_hits++;
        end
        else
        begin
            case (a[31:24])
                REGION_MAIN:
                begin
                    res.target = TGT_MAIN;
                    res.offset = a & MAIN_MASK;
                end
                REGION_WRAM:
                begin
                    res.target = TGT_SHARED;
                    case (wram_split)
                        SPLIT_ALL_SECOND: res.offset = a & MASK_32K;
                        SPLIT_LOW_FIRST:  res.offset = (a & MASK_16K) + UPPER_16K;
                        SPLIT_HIGH_FIRST: res.offset = a & MASK_16K;
                        default:          res.target = TGT_ZERO;
                    endcase
                end
                REGION_IO:
                begin
                    res.offset = a;
                    if (acc.op == OP_WRITE && acc.size == SIZE_BYTE && a == BANK_CTL_ADDR)
                    begin
                        res.target = TGT_BANKCTL;
                        wram_split = acc.data[1:0];
                        bank_writes++;
                    end
                    else
                        res.target = TGT_IO;
                end
                REGION_VRAM:
                begin
                    if (a >= VRAM_LCDC_BASE)
                    begin
                        res.target = TGT_VRAM;
                        res.offset = a;
                    end
                end
                REGION_BIOS9:
                begin
                    if (acc.op == OP_WRITE)
                        res.target = TGT_ZERO;
                    else
                    begin
                        res.target = TGT_BIOS9;
                        res.offset = a & MASK_32K;
                    end
                end
                default:
                begin
                end
            endcase
        end
        res.split = wram_split;
        return res;
    endfunction

    function automatic void check_field(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
            mismatch_count++;
        end
    endfunction

    // Random access, weighted toward region edges, TCM window edges and the
    // bank control address.
    function automatic access_t random_access();
        access_t     acc;
        logic [31:0] a;
        acc.op   = 1'($urandom_range(0, 1));
        acc.cpu  = 1'($urandom_range(0, 1));
        acc.size = 2'($urandom_range(0, 3));
        acc.data = $urandom();
        case ($urandom_range(0, 12))
            0:  a = $urandom();
            1:  a = {REGION_BIOS7, 24'($urandom())};
            2:  a = {REGION_MAIN, 24'($urandom())};
            3:  a = {REGION_WRAM, 24'($urandom())};
            4:  a = PRIV_BASE - 32'd16 + 32'($urandom_range(0, 31));
            5:  a = {REGION_IO, 24'($urandom())};
            6:  a = {REGION_VRAM, 24'($urandom())};
            7:  a = VRAM_LCDC_BASE - 32'd16 + 32'($urandom_range(0, 31));
            8:  a = {REGION_BIOS9, 24'($urandom())};
            9:  a = itcm_top - 32'd16 + 32'($urandom_range(0, 31));
            10: a = dtcm_start - 32'd16 + 32'($urandom_range(0, 31));
            11: a = dtcm_start + dtcm_span - 32'd16 + 32'($urandom_range(0, 31));
            default:
            begin
                a       = BANK_CTL_ADDR;
                acc.op  = OP_WRITE;
                acc.cpu = CPU_SECOND;
                if ($urandom_range(0, 3) != 0)
                    acc.size = SIZE_BYTE;
                if ($urandom_range(0, 4) == 0)
                    a = a ^ 32'($urandom_range(0, 3));
            end
        endcase
        acc.address = a;
        return acc;
    endfunction

    task automatic queue_access(input logic op, input logic cpu, input logic [1:0] size,
                                input logic [31:0] address, input logic [31:0] data);
        access_t acc;
        acc.op      = op;
        acc.cpu     = cpu;
        acc.size    = size;
        acc.address = address;
        acc.data    = data;
        access_queue.push_back(acc);
        queued_count++;
    endtask

    // One configuration transfer: setup phase, access phase and an idle phase.
    task automatic apb_transfer(input logic write, input reg_index_t idx,
                                input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Writes a register, mirrors it and checks the value read back.
    task automatic program_register(input reg_index_t idx, input logic [31:0] value);
        logic [31:0] readback;
        logic [31:0] stored;
        apb_transfer(1'b1, idx, value, readback);
        stored = value;
        case (idx)
            REG_ITCM_ENABLE:
            begin
                stored  = {31'd0, value[0]};
                itcm_on = value[0];
            end
            REG_ITCM_LIMIT:  itcm_top = value;
            REG_DTCM_ENABLE:
            begin
                stored  = {31'd0, value[0]};
                dtcm_on = value[0];
            end
            REG_DTCM_BASE:   dtcm_start = value;
            default:         dtcm_span = value;
        endcase
        apb_transfer(1'b0, idx, '0, readback);
        check_field("register readback", stored, readback);
    endtask

    task automatic program_window(input logic ien, input logic [31:0] ilimit, input logic den,
                                  input logic [31:0] dbase, input logic [31:0] dlength);
        program_register(REG_ITCM_ENABLE, {31'd0, ien});
        program_register(REG_ITCM_LIMIT, ilimit);
        program_register(REG_DTCM_ENABLE, {31'd0, den});
        program_register(REG_DTCM_BASE, dbase);
        program_register(REG_DTCM_LENGTH, dlength);
    endtask

    // Waits until every queued access is taken and every result has come back.
    task automatic wait_drained();
        while (accepted_count != queued_count || expected_decodes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Input driver: offers queued accesses and predicts each accepted transfer.
    always @(posedge clk)
    begin
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_decodes.push_back(decode_access(offered));
                accepted_count++;
            end
            if (s_axis_tvalid && !s_axis_tready)
                stalled_cycles++;
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (access_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    offered = access_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {4'd0, offered.data, offered.address, offered.size,
                                      offered.cpu, offered.op};
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Output monitor: checks each result transfer and paces tready.
    always @(posedge clk)
    begin
        decode_t got;
        decode_t want;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.target  = target_t'(m_axis_tdata[3:0]);
                got.offset  = m_axis_tdata[35:4];
                got.aligned = m_axis_tdata[67:36];
                got.split   = m_axis_tdata[69:68];
                if (expected_decodes.size() == 0)
                begin
                    $display("%0t: result with no access pending, expected none, actual %h",
                             $time, m_axis_tdata);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_decodes.pop_front();
                    results_checked++;
                    check_field("target", 32'(want.target), 32'(got.target));
                    check_field("local_offset", want.offset, got.offset);
                    check_field("aligned_address", want.aligned, got.aligned);
                    check_field("bank_mode_now", 32'(want.split), 32'(got.split));
                end
            end
            // A requested hold-off keeps tready low for a long stretch.
            if (hold_requests != holds_served)
            begin
                holds_served++;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: run timed out with %0d results outstanding", $time,
                     expected_decodes.size());
            $display("dual_cpu_address_decoder verification failed");
            $finish;
        end
    end

    // Stimulus sequence.
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed accesses: region edges, TCM priority, every split mode.
        program_window(1'b1, 32'h0200_1000, 1'b1, 32'h0200_0800, 32'h0000_4000);
        queue_access(OP_READ,  CPU_FIRST,  SIZE_BYTE,  32'h0000_3FFF, 32'h0);
        queue_access(OP_WRITE, CPU_FIRST,  SIZE_WORD,  32'h0000_0010, 32'hFFFF_FFFF);
        queue_access(OP_READ,  CPU_FIRST,  SIZE_WORD,  32'h02FF_FFFF, 32'h0);
        queue_access(OP_READ,  CPU_FIRST,  SIZE_HALF,  32'h03FF_FFFF, 32'h0);
        queue_access(OP_READ,  CPU_FIRST,  SIZE_BYTE,  32'h037F_FFFF, 32'h0);
        queue_access(OP_WRITE, CPU_FIRST,  SIZE_BYTE,  BANK_CTL_ADDR, 32'h3);
        queue_access(OP_READ,  CPU_FIRST,  SIZE_WORD,  32'h0680_0000, 32'h0);
        queue_access(OP_READ,  CPU_SECOND, SIZE_WORD,  32'h0000_0000, 32'h0);
        queue_access(OP_READ,  CPU_SECOND, SIZE_HALF,  32'h0200_0FFF, 32'h0);
        queue_access(OP_READ,  CPU_SECOND, SIZE_BYTE,  32'h0200_1000, 32'h0);
        queue_access(OP_READ,  CPU_SECOND, SIZE_WORD,  32'h0200_4800, 32'h0);
        queue_access(OP_WRITE, CPU_SECOND, SIZE_BYTE,  32'h0300_7FFF, 32'h0);
        queue_access(OP_WRITE, CPU_SECOND, SIZE_BYTE,  BANK_CTL_ADDR, 32'hFFFF_FFFD);
        queue_access(OP_READ,  CPU_SECOND, SIZE_HALF,  32'h0300_7FFF, 32'h0);
        queue_access(OP_READ,  CPU_FIRST,  SIZE_BYTE,  32'h0300_1235, 32'h0);
        queue_access(OP_WRITE, CPU_SECOND, SIZE_CODE3, BANK_CTL_ADDR, 32'h2);
        queue_access(OP_WRITE, CPU_SECOND, SIZE_BYTE,  BANK_CTL_ADDR, 32'h3);
        queue_access(OP_READ,  CPU_SECOND, SIZE_WORD,  32'h0300_0000, 32'h0);
        queue_access(OP_READ,  CPU_FIRST,  SIZE_WORD,  32'h0300_7FFF, 32'h0);
        queue_access(OP_WRITE, CPU_SECOND, SIZE_BYTE,  BANK_CTL_ADDR, 32'h2);
        queue_access(OP_READ,  CPU_FIRST,  SIZE_BYTE,  32'h0300_0010, 32'h0);
        queue_access(OP_READ,  CPU_SECOND, SIZE_BYTE,  32'h0300_4010, 32'h0);
        queue_access(OP_READ,  CPU_SECOND, SIZE_WORD,  32'h067F_FFFF, 32'h0);
        queue_access(OP_READ,  CPU_SECOND, SIZE_CODE3, 32'h0680_0003, 32'h0);
        queue_access(OP_READ,  CPU_SECOND, SIZE_BYTE,  32'hFFFF_FFFF, 32'h0);
        queue_access(OP_WRITE, CPU_SECOND, SIZE_WORD,  32'hFFFF_0000, 32'h0);
        wait_drained();

        // Random phases, each with its own window setting and idling.
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            case (phase)
                0: program_window(1'b1, 32'h0000_8000, 1'b1, 32'h0300_4000, 32'h0000_4000);
                1: program_window(1'b0, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_C000, 32'hFFFF_FFFF);
                2: program_window(1'b1, {REGION_MAIN, 24'($urandom())}, 1'b1,
                                  {REGION_WRAM, 24'($urandom())},
                                  32'($urandom_range(256, 131072)));
                default: program_window(1'b1, 32'h0, 1'b1, 32'h0, 32'h0);
            endcase
            case (phase)
                0:
                begin
                    send_idle_pct = 20;
                    recv_idle_pct = 70;
                end
                1:
                begin
                    send_idle_pct = 70;
                    recv_idle_pct = 20;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            // Back up the output while the input keeps offering accesses.
            if (phase == 2)
                hold_requests++;
            repeat (RANDOM_PER_PHASE)
            begin
                access_queue.push_back(random_access());
                queued_count++;
            end
            wait_drained();
        end

        $display("Covered %0d accesses under five window settings: %0d TCM hits, %0d bank writes.",
                 accepted_count, tcm_hits, bank_writes);
        $display("Checked %0d results; the input was stalled for %0d cycles.",
                 results_checked, stalled_cycles);
        if (mismatch_count == 0 && expected_decodes.size() == 0)
            $display("dual_cpu_address_decoder verification clean");
        else
            $display("dual_cpu_address_decoder verification failed");
        $finish;
    end

endmodule
